@@ design/sexpr_tok_pkg.sv @@
// ----------------------------------------------------------------------------
// S-expression tokenizer package
// Shared scan modes, token kind codes, character codes and the result record.
// ----------------------------------------------------------------------------
package sexpr_tok_pkg;

  // Width of the line number on the result port.
  localparam int unsigned LINE_OUT_BITS = 32;

  // Depth of the result queue and the width of its pointers.
  localparam int unsigned RES_DEPTH     = 4;
  localparam int unsigned RES_PTR_BITS  = $clog2(RES_DEPTH);

  // Scanner mode between characters.
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_WORD    = 2'd2
  } scan_mode_t;

  // Token kind codes.
  localparam logic [1:0] KIND_OPEN   = 2'd0;
  localparam logic [1:0] KIND_CLOSE  = 2'd1;
  localparam logic [1:0] KIND_STRING = 2'd2;
  localparam logic [1:0] KIND_MISC   = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // One result transaction.
  typedef struct packed {
    logic [7:0]               token_char;
    logic [1:0]               token_kind;
    logic                     token_first;
    logic                     token_last;
    logic [LINE_OUT_BITS-1:0] token_line;
    logic                     unpaired_quote;
    logic                     run_last;
  } result_t;

  // True for the whitespace characters.
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  // Builds a result record; run_last is set later by the caller.
  function automatic result_t make_res(input logic [7:0]               ch,
                                       input logic [1:0]               kind,
                                       input logic                     first,
                                       input logic                     last,
                                       input logic [LINE_OUT_BITS-1:0] line,
                                       input logic                     err);
    result_t r;
    r.token_char     = ch;
    r.token_kind     = kind;
    r.token_first    = first;
    r.token_last     = last;
    r.token_line     = line;
    r.unpaired_quote = err;
    r.run_last       = 1'b0;
    return r;
  endfunction

endpackage

@@ design/sexpr_tok_if.sv @@
// ----------------------------------------------------------------------------
// S-expression tokenizer channels
// Character input channel and token result channel, valid/ready handshake.
// ----------------------------------------------------------------------------

// Source characters.
interface sexpr_tok_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

// Token results.
interface sexpr_tok_token_if;
  logic        valid;
  logic        ready;
  logic [7:0]  token_char;
  logic [1:0]  token_kind;
  logic        token_first;
  logic        token_last;
  logic [31:0] token_line;
  logic        unpaired_quote;
  logic        run_last;

  modport source (output valid, output token_char, output token_kind,
                  output token_first, output token_last, output token_line,
                  output unpaired_quote, output run_last, input ready);
  modport sink   (input valid, input token_char, input token_kind,
                  input token_first, input token_last, input token_line,
                  input unpaired_quote, input run_last, output ready);
endinterface

@@ design/sexpr_tokenizer.sv @@
// ----------------------------------------------------------------------------
// S-expression tokenizer
// Takes one character per cycle while ready and emits token characters with
// kind, first and last marks and the source line of each token. A character
// that causes results has them written into a four-entry result queue at the
// edge that accepts it, one or two at a time; the token channel is fed from
// the head of the queue, which drains one transaction per cycle while the
// sink is ready. The character channel stays ready while the queue has two
// free entries. A character that gives two results (a word closed by a paren,
// or end of input after a word with an open quote) ends a word whose first
// character gave none, so with a sink that takes every cycle the queue never
// holds more than two entries and one character is accepted each cycle; only
// stalls on the token channel hold the input off. Word characters leave one
// character late so that the final one can carry its last mark. End of input
// flushes the pending word, reports an open quote, and restarts at line 1.
// ----------------------------------------------------------------------------
module sexpr_tokenizer #(
  parameter int unsigned LINE_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  sexpr_tok_char_if.sink           chars,
  sexpr_tok_token_if.source        tokens
);

  localparam int unsigned OUT_BITS = sexpr_tok_pkg::LINE_OUT_BITS;
  localparam int unsigned PTR_BITS = sexpr_tok_pkg::RES_PTR_BITS;
  localparam int unsigned CNT_BITS = PTR_BITS + 1;

  // Scanner state.
  sexpr_tok_pkg::scan_mode_t mode, mode_next;
  logic                      quote_open, quote_open_next;
  logic                      held_valid, held_valid_next;
  logic [7:0]                held_char, held_char_next;
  logic                      held_first, held_first_next;
  logic [1:0]                word_kind, word_kind_next;
  logic [LINE_BITS-1:0]      word_line, word_line_next;
  logic [LINE_BITS-1:0]      line_count, line_count_next;

  // Results of the current character.
  sexpr_tok_pkg::result_t res0, res1, res_tmp;
  logic [1:0]             n_res;
  logic                   do_idle;
  logic                   delim;
  logic [7:0]             c;

  logic [LINE_BITS-1:0]   line_bumped;
  logic [OUT_BITS-1:0]    word_line_out;
  logic [OUT_BITS-1:0]    line_count_out;

  // Result queue.
  sexpr_tok_pkg::result_t res_mem [sexpr_tok_pkg::RES_DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]    count;
  logic                   accept;
  logic                   pop;

  assign c      = chars.char_in;
  assign accept = chars.valid && chars.ready;
  assign pop    = tokens.valid && tokens.ready;

  // Accept while two queue entries are free.
  assign chars.ready = (count <= CNT_BITS'(sexpr_tok_pkg::RES_DEPTH - 2));

  // Saturating line increment.
  assign line_bumped = (&line_count) ? line_count : line_count + LINE_BITS'(1);

  // Line numbers at the port width, saturating when the counter is wider.
  generate
    if (LINE_BITS > OUT_BITS) begin : g_line_wide
      assign word_line_out  = (|word_line[LINE_BITS-1:OUT_BITS]) ?
                              {OUT_BITS{1'b1}} : word_line[OUT_BITS-1:0];
      assign line_count_out = (|line_count[LINE_BITS-1:OUT_BITS]) ?
                              {OUT_BITS{1'b1}} : line_count[OUT_BITS-1:0];
    end else if (LINE_BITS == OUT_BITS) begin : g_line_same
      assign word_line_out  = word_line;
      assign line_count_out = line_count;
    end else begin : g_line_narrow
      assign word_line_out  = {{(OUT_BITS-LINE_BITS){1'b0}}, word_line};
      assign line_count_out = {{(OUT_BITS-LINE_BITS){1'b0}}, line_count};
    end
  endgenerate

  // Next scanner state and the results of one character.
  always_comb begin
    mode_next       = mode;
    quote_open_next = quote_open;
    held_valid_next = held_valid;
    held_char_next  = held_char;
    held_first_next = held_first;
    word_kind_next  = word_kind;
    word_line_next  = word_line;
    line_count_next = line_count;
    n_res           = 2'd0;
    res0            = '0;
    res1            = '0;
    res_tmp         = '0;
    do_idle         = 1'b0;
    delim           = 1'b0;

    if (chars.end_of_input) begin
      // Flush the pending word and report an open quote.
      if (mode == sexpr_tok_pkg::MODE_WORD) begin
        if (held_valid) begin
          res_tmp = sexpr_tok_pkg::make_res(held_char, word_kind, held_first, 1'b1,
                                            word_line_out, 1'b0);
          res0    = res_tmp;
          n_res   = 2'd1;
        end
        if (quote_open) begin
          res_tmp = sexpr_tok_pkg::make_res(8'd0, word_kind, 1'b0, 1'b0,
                                            word_line_out, 1'b1);
          if (n_res == 2'd0) begin
            res0 = res_tmp;
          end else begin
            res1 = res_tmp;
          end
          n_res = n_res + 2'd1;
        end
      end
      mode_next       = sexpr_tok_pkg::MODE_IDLE;
      quote_open_next = 1'b0;
      held_valid_next = 1'b0;
      held_char_next  = 8'd0;
      held_first_next = 1'b0;
      word_kind_next  = sexpr_tok_pkg::KIND_MISC;
      word_line_next  = LINE_BITS'(1);
      line_count_next = LINE_BITS'(1);
    end else begin
      case (mode)
        sexpr_tok_pkg::MODE_COMMENT: begin
          if (c == sexpr_tok_pkg::CH_NL) begin
            line_count_next = line_bumped;
            mode_next       = sexpr_tok_pkg::MODE_IDLE;
          end
        end
        sexpr_tok_pkg::MODE_WORD: begin
          delim = !quote_open &&
                  ((c == sexpr_tok_pkg::CH_LPAREN) || (c == sexpr_tok_pkg::CH_RPAREN) ||
                   (c == sexpr_tok_pkg::CH_SEMI) || sexpr_tok_pkg::is_space(c));
          if (held_valid) begin
            res0  = sexpr_tok_pkg::make_res(held_char, word_kind, held_first, delim,
                                            word_line_out, 1'b0);
            n_res = 2'd1;
          end
          if (delim) begin
            // The word ends here; the delimiter is scanned as in idle.
            held_valid_next = 1'b0;
            held_first_next = 1'b0;
            quote_open_next = 1'b0;
            mode_next       = sexpr_tok_pkg::MODE_IDLE;
            do_idle         = 1'b1;
          end else begin
            held_valid_next = 1'b1;
            held_char_next  = c;
            held_first_next = 1'b0;
            if (c == sexpr_tok_pkg::CH_QUOTE) begin
              quote_open_next = !quote_open;
            end
            if (c == sexpr_tok_pkg::CH_NL) begin
              line_count_next = line_bumped;
            end
          end
        end
        default: begin
          mode_next = sexpr_tok_pkg::MODE_IDLE;
          do_idle   = 1'b1;
        end
      endcase

      // Character seen between tokens.
      if (do_idle) begin
        if (c == sexpr_tok_pkg::CH_NL) begin
          line_count_next = line_bumped;
        end else if (sexpr_tok_pkg::is_space(c)) begin
          mode_next = sexpr_tok_pkg::MODE_IDLE;
        end else if (c == sexpr_tok_pkg::CH_SEMI) begin
          mode_next = sexpr_tok_pkg::MODE_COMMENT;
        end else if ((c == sexpr_tok_pkg::CH_LPAREN) ||
                     (c == sexpr_tok_pkg::CH_RPAREN)) begin
          res_tmp = sexpr_tok_pkg::make_res(c,
                      (c == sexpr_tok_pkg::CH_LPAREN) ? sexpr_tok_pkg::KIND_OPEN :
                                                        sexpr_tok_pkg::KIND_CLOSE,
                      1'b1, 1'b1, line_count_out, 1'b0);
          if (n_res == 2'd0) begin
            res0 = res_tmp;
          end else begin
            res1 = res_tmp;
          end
          n_res = n_res + 2'd1;
        end else begin
          mode_next       = sexpr_tok_pkg::MODE_WORD;
          quote_open_next = (c == sexpr_tok_pkg::CH_QUOTE);
          word_kind_next  = (c == sexpr_tok_pkg::CH_QUOTE) ? sexpr_tok_pkg::KIND_STRING :
                                                             sexpr_tok_pkg::KIND_MISC;
          word_line_next  = line_count;
          held_valid_next = 1'b1;
          held_char_next  = c;
          held_first_next = 1'b1;
        end
      end
    end

    // Mark the last result of this character.
    if (n_res == 2'd1) begin
      res0.run_last = 1'b1;
    end else if (n_res == 2'd2) begin
      res1.run_last = 1'b1;
    end
  end

  // Scanner state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= sexpr_tok_pkg::MODE_IDLE;
      quote_open <= 1'b0;
      held_valid <= 1'b0;
      held_char  <= 8'd0;
      held_first <= 1'b0;
      word_kind  <= sexpr_tok_pkg::KIND_MISC;
      word_line  <= LINE_BITS'(1);
      line_count <= LINE_BITS'(1);
    end else if (accept) begin
      mode       <= mode_next;
      quote_open <= quote_open_next;
      held_valid <= held_valid_next;
      held_char  <= held_char_next;
      held_first <= held_first_next;
      word_kind  <= word_kind_next;
      word_line  <= word_line_next;
      line_count <= line_count_next;
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (accept && (n_res != 2'd0)) begin
      res_mem[wr_ptr] <= res0;
    end
    if (accept && (n_res == 2'd2)) begin
      res_mem[wr_ptr + PTR_BITS'(1)] <= res1;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + PTR_BITS'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      count <= count + (accept ? CNT_BITS'(n_res) : CNT_BITS'(0))
                     - (pop ? CNT_BITS'(1) : CNT_BITS'(0));
    end
  end

  // Output transaction from the head of the queue.
  assign tokens.valid          = (count != '0);
  assign tokens.token_char     = res_mem[rd_ptr].token_char;
  assign tokens.token_kind     = res_mem[rd_ptr].token_kind;
  assign tokens.token_first    = res_mem[rd_ptr].token_first;
  assign tokens.token_last     = res_mem[rd_ptr].token_last;
  assign tokens.token_line     = res_mem[rd_ptr].token_line;
  assign tokens.unpaired_quote = res_mem[rd_ptr].unpaired_quote;
  assign tokens.run_last       = res_mem[rd_ptr].run_last;

endmodule

@@ dv/sexpr_tokenizer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// S-expression tokenizer testbench
// Streams characters into the tokenizer and checks every token transaction
// against a cycle-free model of the lexer, or hand-typed ones for typed rows.
// A short table of directed characters covers parens, words, strings,
// comments, quoted newlines and the end-of-input cases. A long weighted random
// run follows, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module sexpr_tokenizer_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_CHARS = 470;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned GAP_PCT      = 18;

  // One directed character, with its expected tokens when typed in by hand.
  typedef struct {
    logic [7:0]             ch;
    logic                   eoi;
    bit                     typed;
    int unsigned            n;
    sexpr_tok_pkg::result_t r0;
    sexpr_tok_pkg::result_t r1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  sexpr_tok_char_if  char_ch ();
  sexpr_tok_token_if tok_ch ();

  sexpr_tokenizer u_dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (char_ch),
    .tokens (tok_ch)
  );

  // Lexer state mirrored by the testbench.
  sexpr_tok_pkg::scan_mode_t lex_mode;
  logic        lex_quote;
  logic        hold_ok;
  logic [7:0]  hold_ch;
  logic        hold_first;
  logic [1:0]  word_kd;
  logic [31:0] word_ln;
  logic [31:0] line_no;

  sexpr_tok_pkg::result_t step_tokens[$];
  sexpr_tok_pkg::result_t token_q[$];
  stim_row_t              plan[$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned gap_pct = GAP_PCT;
  int unsigned stall_pct = GAP_PCT;

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit in case the tokenizer stops making progress.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Whitespace test used by the lexer model.
  function automatic bit blank(input logic [7:0] c);
    case (c)
      sexpr_tok_pkg::CH_SPACE, sexpr_tok_pkg::CH_TAB, sexpr_tok_pkg::CH_NL,
      sexpr_tok_pkg::CH_VT, sexpr_tok_pkg::CH_FF, sexpr_tok_pkg::CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic lex_clear();
    lex_mode   = sexpr_tok_pkg::MODE_IDLE;
    lex_quote  = 1'b0;
    hold_ok    = 1'b0;
    hold_ch    = '0;
    hold_first = 1'b0;
    word_kd    = sexpr_tok_pkg::KIND_MISC;
    word_ln    = 32'd1;
    line_no    = 32'd1;
  endtask

  // The line counter sticks at its maximum.
  task automatic next_line();
    if (line_no != '1) line_no = line_no + 1;
  endtask

  task automatic emit_token(input logic [7:0] ch, input logic [1:0] kind,
                            input logic first, input logic last,
                            input logic [31:0] line, input logic err);
    step_tokens.push_back(sexpr_tok_pkg::result_t'{ch, kind, first, last, line, err, 1'b0});
  endtask

  // Character seen while no word is open.
  task automatic between_tokens(input logic [7:0] c);
    case (c)
      sexpr_tok_pkg::CH_NL:     next_line();
      sexpr_tok_pkg::CH_SEMI:   lex_mode = sexpr_tok_pkg::MODE_COMMENT;
      sexpr_tok_pkg::CH_LPAREN:
        emit_token(c, sexpr_tok_pkg::KIND_OPEN, 1'b1, 1'b1, line_no, 1'b0);
      sexpr_tok_pkg::CH_RPAREN:
        emit_token(c, sexpr_tok_pkg::KIND_CLOSE, 1'b1, 1'b1, line_no, 1'b0);
      default: begin
        if (!blank(c)) begin
          lex_mode   = sexpr_tok_pkg::MODE_WORD;
          lex_quote  = (c == sexpr_tok_pkg::CH_QUOTE);
          word_kd    = (c == sexpr_tok_pkg::CH_QUOTE) ? sexpr_tok_pkg::KIND_STRING :
                                                        sexpr_tok_pkg::KIND_MISC;
          word_ln    = line_no;
          hold_ok    = 1'b1;
          hold_ch    = c;
          hold_first = 1'b1;
        end
      end
    endcase
  endtask

  // Tokens caused by one accepted character, left in step_tokens.
  task automatic lex_char(input logic [7:0] c, input logic eoi);
    step_tokens.delete();
    if (eoi) begin
      if (lex_mode == sexpr_tok_pkg::MODE_WORD) begin
        if (hold_ok) emit_token(hold_ch, word_kd, hold_first, 1'b1, word_ln, 1'b0);
        if (lex_quote) emit_token(8'h00, word_kd, 1'b0, 1'b0, word_ln, 1'b1);
      end
      lex_clear();
    end else if (lex_mode == sexpr_tok_pkg::MODE_COMMENT) begin
      if (c == sexpr_tok_pkg::CH_NL) begin
        next_line();
        lex_mode = sexpr_tok_pkg::MODE_IDLE;
      end
    end else if (lex_mode == sexpr_tok_pkg::MODE_WORD) begin
      if (!lex_quote &&
          (c == sexpr_tok_pkg::CH_LPAREN || c == sexpr_tok_pkg::CH_RPAREN ||
           c == sexpr_tok_pkg::CH_SEMI || blank(c))) begin
        // The delimiter closes the word and is then lexed on its own.
        if (hold_ok) emit_token(hold_ch, word_kd, hold_first, 1'b1, word_ln, 1'b0);
        hold_ok    = 1'b0;
        hold_first = 1'b0;
        lex_quote  = 1'b0;
        lex_mode   = sexpr_tok_pkg::MODE_IDLE;
        between_tokens(c);
      end else begin
        if (hold_ok) emit_token(hold_ch, word_kd, hold_first, 1'b0, word_ln, 1'b0);
        hold_ok    = 1'b1;
        hold_ch    = c;
        hold_first = 1'b0;
        if (c == sexpr_tok_pkg::CH_QUOTE) lex_quote = !lex_quote;
        if (c == sexpr_tok_pkg::CH_NL) next_line();
      end
    end else begin
      lex_mode = sexpr_tok_pkg::MODE_IDLE;
      between_tokens(c);
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].run_last = 1'b1;
  endtask

  task automatic report_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    errors++;
    $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_error(what, got, want);
  endtask

  // Compare one token transaction with the oldest expected token.
  task automatic check_token();
    sexpr_tok_pkg::result_t want;
    if (token_q.size() == 0) begin
      report_error("unexpected token_char", tok_ch.token_char, 0);
    end else begin
      want = token_q.pop_front();
      check_field("token_char", tok_ch.token_char, want.token_char);
      check_field("token_kind", tok_ch.token_kind, want.token_kind);
      check_field("token_first", tok_ch.token_first, want.token_first);
      check_field("token_last", tok_ch.token_last, want.token_last);
      check_field("token_line", tok_ch.token_line, want.token_line);
      check_field("unpaired_quote", tok_ch.unpaired_quote, want.unpaired_quote);
      check_field("run_last", tok_ch.run_last, want.run_last);
    end
  endtask

  // Drive one character, wait for its transaction, then queue its tokens.
  task automatic send_char(input stim_row_t row);
    if ($urandom_range(99) < gap_pct) begin
      char_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    char_ch.valid        <= 1'b1;
    char_ch.char_in      <= row.ch;
    char_ch.end_of_input <= row.eoi;
    do @(posedge clk); while (!char_ch.ready);
    lex_char(row.ch, row.eoi);
    if (row.typed) begin
      if (row.n > 0) token_q.push_back(row.r0);
      if (row.n > 1) token_q.push_back(row.r1);
    end else begin
      foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
    end
  endtask

  // Hold the input off until every expected token has come out.
  task automatic wait_drained();
    char_ch.valid <= 1'b0;
    @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
  endtask

  // Weighted character mix: mostly words, parens and separators.
  function automatic logic [7:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 12) return 8'($urandom_range(255));
    if (roll < 24) return $urandom_range(1) ? sexpr_tok_pkg::CH_LPAREN :
                                              sexpr_tok_pkg::CH_RPAREN;
    if (roll < 40) begin
      case ($urandom_range(5))
        0: return sexpr_tok_pkg::CH_SPACE;
        1: return sexpr_tok_pkg::CH_TAB;
        2: return sexpr_tok_pkg::CH_VT;
        3: return sexpr_tok_pkg::CH_FF;
        4: return sexpr_tok_pkg::CH_CR;
        default: return sexpr_tok_pkg::CH_SPACE;
      endcase
    end
    if (roll < 48) return sexpr_tok_pkg::CH_NL;
    if (roll < 52) return sexpr_tok_pkg::CH_SEMI;
    if (roll < 60) return sexpr_tok_pkg::CH_QUOTE;
    if (roll < 90) return 8'("a") + 8'($urandom_range(25));
    return 8'("0") + 8'($urandom_range(9));
  endfunction

  // Output side: check accepted tokens and stall at random.
  initial begin
    tok_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tok_ch.valid && tok_ch.ready) check_token();
      tok_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Input side: reset, directed table, random stream, drain.
  initial begin
    stim_row_t row;

    rst                  <= 1'b1;
    char_ch.valid        <= 1'b0;
    char_ch.char_in      <= '0;
    char_ch.end_of_input <= 1'b0;
    lex_clear();

    // Parens, a word with a high byte, and a word closed by a paren.
    plan.push_back('{sexpr_tok_pkg::CH_LPAREN, 1'b0, 1'b1, 1,
                     sexpr_tok_pkg::result_t'{sexpr_tok_pkg::CH_LPAREN,
                       sexpr_tok_pkg::KIND_OPEN, 1'b1, 1'b1, 32'd1, 1'b0, 1'b1}, '0});
    plan.push_back('{sexpr_tok_pkg::CH_RPAREN, 1'b0, 1'b1, 1,
                     sexpr_tok_pkg::result_t'{sexpr_tok_pkg::CH_RPAREN,
                       sexpr_tok_pkg::KIND_CLOSE, 1'b1, 1'b1, 32'd1, 1'b0, 1'b1}, '0});
    plan.push_back('{"a", 1'b0, 1'b1, 0, '0, '0});
    plan.push_back('{8'hFF, 1'b0, 1'b1, 1,
                     sexpr_tok_pkg::result_t'{"a", sexpr_tok_pkg::KIND_MISC,
                       1'b1, 1'b0, 32'd1, 1'b0, 1'b1}, '0});
    plan.push_back('{sexpr_tok_pkg::CH_LPAREN, 1'b0, 1'b1, 2,
                     sexpr_tok_pkg::result_t'{8'hFF, sexpr_tok_pkg::KIND_MISC,
                       1'b0, 1'b1, 32'd1, 1'b0, 1'b0},
                     sexpr_tok_pkg::result_t'{sexpr_tok_pkg::CH_LPAREN,
                       sexpr_tok_pkg::KIND_OPEN, 1'b1, 1'b1, 32'd1, 1'b0, 1'b1}});
    // A comment that hides a paren, then a string holding a newline and a
    // semicolon, then words closed by a paren, a vertical tab and a form feed.
    plan.push_back('{sexpr_tok_pkg::CH_NL, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{sexpr_tok_pkg::CH_SEMI, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{sexpr_tok_pkg::CH_LPAREN, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{sexpr_tok_pkg::CH_NL, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{sexpr_tok_pkg::CH_QUOTE, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{sexpr_tok_pkg::CH_NL, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{sexpr_tok_pkg::CH_SEMI, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{sexpr_tok_pkg::CH_QUOTE, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{"x", 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{sexpr_tok_pkg::CH_RPAREN, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{"k", 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{sexpr_tok_pkg::CH_VT, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{"m", 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{sexpr_tok_pkg::CH_FF, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{sexpr_tok_pkg::CH_CR, 1'b0, 1'b0, 0, '0, '0});
    // End of input inside an open string: flush, then the unpaired quote error.
    plan.push_back('{sexpr_tok_pkg::CH_QUOTE, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{8'hFF, 1'b1, 1'b1, 2,
                     sexpr_tok_pkg::result_t'{sexpr_tok_pkg::CH_QUOTE,
                       sexpr_tok_pkg::KIND_STRING, 1'b1, 1'b1, 32'd4, 1'b0, 1'b0},
                     sexpr_tok_pkg::result_t'{8'h00, sexpr_tok_pkg::KIND_STRING,
                       1'b0, 1'b0, 32'd4, 1'b1, 1'b1}});
    // A new stream restarts at line one; end of input flushes a word.
    plan.push_back('{"b", 1'b0, 1'b1, 0, '0, '0});
    plan.push_back('{8'h00, 1'b1, 1'b1, 1,
                     sexpr_tok_pkg::result_t'{"b", sexpr_tok_pkg::KIND_MISC,
                       1'b1, 1'b1, 32'd1, 1'b0, 1'b1}, '0});
    // End of input inside a comment and while idle gives nothing.
    plan.push_back('{sexpr_tok_pkg::CH_SEMI, 1'b0, 1'b0, 0, '0, '0});
    plan.push_back('{8'h5A, 1'b1, 1'b1, 0, '0, '0});
    plan.push_back('{8'h00, 1'b1, 1'b1, 0, '0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_char(plan[i]);
    wait_drained();

    // Random stream, with one stretch free of gaps and stalls.
    for (int unsigned k = 0; k < RANDOM_CHARS; k++) begin
      if (k == 100) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      if (k == 220) begin
        gap_pct   = GAP_PCT;
        stall_pct = GAP_PCT;
      end
      if (k == 300) wait_drained();
      row.typed = 1'b0;
      row.n     = 0;
      row.r0    = '0;
      row.r1    = '0;
      row.eoi   = ($urandom_range(99) < 2);
      row.ch    = row.eoi ? 8'($urandom_range(255)) : pick_char();
      send_char(row);
    end

    // Let the last tokens drain, then watch the idle output for strays.
    char_ch.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sexpr_tokenizer.f @@
design/sexpr_tok_pkg.sv
design/sexpr_tok_if.sv
design/sexpr_tokenizer.sv
dv/sexpr_tokenizer_tb.sv
